>>> sv/drive_pid_position_controller_top_macros.svh
// Assertion shorthands shared by the controller modules.
`ifndef DRIVE_PID_POSITION_CONTROLLER_TOP_MACROS_SVH
`define DRIVE_PID_POSITION_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dpc_pkg.sv
package dpc_pkg;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_TICK           = 2'd0,
        OP_START_STRAIGHT = 2'd1,
        OP_START_TURN     = 2'd2,
        OP_RESERVED       = 2'd3
    } dpc_op_t;

    // Configuration register indexes.
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 31;
    localparam logic [CfgIndexWidth-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_POWER_SCALE    = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_MOVE_SCALE     = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_TURN_SCALE     = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_EXIT_THRESHOLD = 3'd6;

    // Divider sizes: dividend is the error magnitude shifted up by 16 bits.
    localparam int unsigned DivNWidth = 48;
    localparam int unsigned DivDWidth = 32;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD_START,
        CMD_LATCH,
        CMD_STEP_MUL,
        CMD_POS,
        CMD_ERR,
        CMD_DIV_START,
        CMD_DIV_LOAD,
        CMD_PS_MUL,
        CMD_PS_DONE,
        CMD_MUL_P,
        CMD_MUL_I,
        CMD_MUL_D,
        CMD_ACC,
        CMD_FINISH
    } dpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic sp_zero;
        logic div_done;
        logic out_free;
    } dpc_status_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Divide by 2^16, truncating toward zero.
    function automatic logic signed [63:0] trunc_q16(input logic signed [63:0] v);
        logic signed [63:0] adj;
        adj = v + (v[63] ? 64'sd65535 : 64'sd0);
        return adj >>> 16;
    endfunction

endpackage

>>> sv/dpc_div.sv
module dpc_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [dpc_pkg::DivNWidth-1:0]    dividend,
    input  logic [dpc_pkg::DivDWidth-1:0]    divisor,
    output logic                             done,
    output logic [dpc_pkg::DivNWidth-1:0]    quotient
);

    localparam int unsigned CountWidth = $clog2(dpc_pkg::DivNWidth);
    localparam logic [CountWidth-1:0] LastStep = CountWidth'(dpc_pkg::DivNWidth - 1);

    logic [dpc_pkg::DivNWidth-1:0] quo_reg;
    logic [dpc_pkg::DivDWidth-1:0] rem_reg;
    logic [dpc_pkg::DivDWidth-1:0] divisor_reg;
    logic [CountWidth-1:0]         count_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [dpc_pkg::DivDWidth+1:0] trial;
    logic                          fits;
    logic [dpc_pkg::DivDWidth-1:0] rem_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {1'b0, rem_reg, quo_reg[dpc_pkg::DivNWidth-1]} - {2'b00, divisor_reg};
        fits  = !trial[dpc_pkg::DivDWidth+1];
        rem_next = fits ? trial[dpc_pkg::DivDWidth-1:0]
                        : {rem_reg[dpc_pkg::DivDWidth-2:0], quo_reg[dpc_pkg::DivNWidth-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= LastStep;
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[dpc_pkg::DivNWidth-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/dpc_datapath.sv
`include "drive_pid_position_controller_top_macros.svh"

module dpc_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  dpc_pkg::dpc_cmd_t                      cmd,
    output dpc_pkg::dpc_status_t                   status,
    input  logic [1:0]                             s_operation,
    input  logic signed [31:0]                     s_target,
    input  logic signed [23:0]                     s_left_count,
    input  logic signed [23:0]                     s_right_count,
    input  logic                                   cfg_write_en,
    input  logic [dpc_pkg::CfgIndexWidth-1:0]      cfg_index,
    input  logic [dpc_pkg::CfgDataWidth-1:0]       cfg_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [31:0]                     m_motor_power,
    output logic signed [31:0]                     m_position_error,
    output logic                                   m_finished
);

    // Configuration registers.
    logic signed [23:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic        [16:0] power_scale_reg;
    logic        [23:0] move_scale_reg, turn_scale_reg;
    logic        [30:0] exit_threshold_reg;

    // Controller state and working registers.
    logic signed [31:0] sp_reg, pos_reg, sum_reg, last_reg, err_reg, deriv_reg, prop_reg;
    logic signed [23:0] left_reg, right_reg;
    logic               turn_reg, active_reg, q_neg_reg;
    logic signed [57:0] prod_reg, acc_reg;
    logic               m_valid_reg, m_finished_reg;
    logic signed [31:0] m_power_reg, m_error_reg;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [24:0] sum_lr, diff_lr, avg_lr;
    logic signed [31:0] step_sat, pos_next, err_next, sum_next, deriv_next;
    logic signed [31:0] prop_div, prop_scaled, power_next, thr;
    logic signed [63:0] prop_trunc;
    logic        [31:0] err_mag, sp_mag;
    logic signed [63:0] q_signed;
    logic               done_next, div_done;
    logic [dpc_pkg::DivNWidth-1:0] div_quot;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg         <= 24'sd65536;
            gain_i_reg         <= 24'sd65536;
            gain_d_reg         <= 24'sd65536;
            power_scale_reg    <= 17'd55706;
            move_scale_reg     <= 24'd65536;
            turn_scale_reg     <= 24'd65536;
            exit_threshold_reg <= 31'd6554;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                dpc_pkg::REG_GAIN_P:         gain_p_reg         <= cfg_data[23:0];
                dpc_pkg::REG_GAIN_I:         gain_i_reg         <= cfg_data[23:0];
                dpc_pkg::REG_GAIN_D:         gain_d_reg         <= cfg_data[23:0];
                dpc_pkg::REG_POWER_SCALE:    power_scale_reg    <= cfg_data[16:0];
                dpc_pkg::REG_MOVE_SCALE:     move_scale_reg     <= cfg_data[23:0];
                dpc_pkg::REG_TURN_SCALE:     turn_scale_reg     <= cfg_data[23:0];
                dpc_pkg::REG_EXIT_THRESHOLD: exit_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Wheel average (truncated toward zero) and wheel difference.
    always_comb begin
        sum_lr  = 25'(left_reg) + 25'(right_reg);
        diff_lr = 25'(left_reg) - 25'(right_reg);
        avg_lr  = (sum_lr + $signed({24'b0, sum_lr[24]})) >>> 1;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd)
            dpc_pkg::CMD_STEP_MUL: begin
                mul_a = turn_reg ? 33'(diff_lr) : 33'(avg_lr);
                mul_b = turn_reg ? $signed({1'b0, turn_scale_reg})
                                 : $signed({1'b0, move_scale_reg});
            end
            dpc_pkg::CMD_PS_MUL: begin
                mul_a = 33'(prop_reg);
                mul_b = $signed({8'b0, power_scale_reg});
            end
            dpc_pkg::CMD_MUL_P: begin
                mul_a = 33'(prop_reg);
                mul_b = 25'(gain_p_reg);
            end
            dpc_pkg::CMD_MUL_I: begin
                mul_a = 33'(sum_reg);
                mul_b = 25'(gain_i_reg);
            end
            dpc_pkg::CMD_MUL_D: begin
                mul_a = 33'(deriv_reg);
                mul_b = 25'(gain_d_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Arithmetic of one control step; sums, differences and results saturate to 32 bits.
    always_comb begin
        step_sat    = dpc_pkg::sat32(64'(prod_reg));
        pos_next    = dpc_pkg::sat32(64'(pos_reg) + 64'(step_sat));
        err_next    = dpc_pkg::sat32(64'(sp_reg) - 64'(pos_reg));
        sum_next    = dpc_pkg::sat32(64'(sum_reg) + 64'(err_reg));
        deriv_next  = dpc_pkg::sat32(64'(err_reg) - 64'(last_reg));
        err_mag     = err_reg[31] ? (~err_reg + 32'd1) : err_reg;
        sp_mag      = sp_reg[31] ? (~sp_reg + 32'd1) : sp_reg;
        q_signed    = q_neg_reg ? -$signed({16'b0, div_quot}) : $signed({16'b0, div_quot});
        prop_div    = dpc_pkg::sat32(q_signed);
        prop_trunc  = dpc_pkg::trunc_q16(64'(prod_reg));
        prop_scaled = prop_trunc[31:0];
        power_next  = dpc_pkg::sat32(dpc_pkg::trunc_q16(64'(acc_reg)));
        thr         = $signed({1'b0, exit_threshold_reg});
        done_next   = (err_reg <= thr) && (deriv_reg <= thr);
    end

    dpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((cmd == dpc_pkg::CMD_DIV_START) && (sp_reg != '0)),
        .dividend ({err_mag, 16'b0}),
        .divisor  (sp_mag),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Control state: mode, arming and the output slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            turn_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd == dpc_pkg::CMD_LOAD_START) begin
                active_reg <= 1'b1;
                turn_reg   <= (dpc_pkg::dpc_op_t'(s_operation) == dpc_pkg::OP_START_TURN);
            end
            if (cmd == dpc_pkg::CMD_FINISH) begin
                m_valid_reg <= 1'b1;
                if (done_next) begin
                    active_reg <= 1'b0;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers, stepped by the controller.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg   <= '0;
            pos_reg  <= '0;
            sum_reg  <= '0;
            last_reg <= '0;
        end else begin
            unique case (cmd)
                dpc_pkg::CMD_LOAD_START: begin
                    sp_reg   <= s_target;
                    pos_reg  <= '0;
                    sum_reg  <= '0;
                    last_reg <= '0;
                end
                dpc_pkg::CMD_POS: pos_reg <= pos_next;
                dpc_pkg::CMD_DIV_START: sum_reg <= sum_next;
                dpc_pkg::CMD_FINISH: begin
                    last_reg <= err_reg;
                    if (done_next) begin
                        pos_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        if (cmd == dpc_pkg::CMD_STEP_MUL || cmd == dpc_pkg::CMD_PS_MUL ||
            cmd == dpc_pkg::CMD_MUL_P || cmd == dpc_pkg::CMD_MUL_I ||
            cmd == dpc_pkg::CMD_MUL_D) begin
            prod_reg <= mul_a * mul_b;
        end
        unique case (cmd)
            dpc_pkg::CMD_LATCH: begin
                left_reg  <= s_left_count;
                right_reg <= s_right_count;
            end
            dpc_pkg::CMD_ERR: err_reg <= err_next;
            dpc_pkg::CMD_DIV_START: begin
                deriv_reg <= deriv_next;
                q_neg_reg <= err_reg[31] ^ sp_reg[31];
            end
            dpc_pkg::CMD_DIV_LOAD: prop_reg <= prop_div;
            dpc_pkg::CMD_PS_DONE: prop_reg <= (sp_reg == '0) ? '0 : prop_scaled;
            dpc_pkg::CMD_MUL_I: acc_reg <= prod_reg;
            dpc_pkg::CMD_MUL_D: acc_reg <= acc_reg + prod_reg;
            dpc_pkg::CMD_ACC: acc_reg <= acc_reg + prod_reg;
            dpc_pkg::CMD_FINISH: begin
                m_power_reg    <= power_next;
                m_error_reg    <= err_reg;
                m_finished_reg <= done_next;
            end
            default: ;
        endcase
    end

    assign status.active   = active_reg;
    assign status.sp_zero  = (sp_reg == '0);
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_motor_power    = m_power_reg;
    assign m_position_error = m_error_reg;
    assign m_finished       = m_finished_reg;

    // A finishing tick disarms the loop and clears the position.
    `DPC_ASSERT_NEXT(a_done_disarms, (cmd == dpc_pkg::CMD_FINISH) && done_next, !active_reg && (pos_reg == '0), "finished tick left controller armed")
    // A result is only written into a free output slot.
    `DPC_ASSERT_NOW(a_no_overwrite, cmd == dpc_pkg::CMD_FINISH, !m_valid_reg || m_ready, "result overwrote pending item")
    // The divider never runs on a zero setpoint.
    `DPC_ASSERT_NOW(a_div_nonzero, div_done, sp_reg != '0, "divider ran on zero setpoint")

endmodule

>>> sv/dpc_ctrl.sv
`include "drive_pid_position_controller_top_macros.svh"

module dpc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  dpc_pkg::dpc_status_t status,
    output dpc_pkg::dpc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_MUL,
        ST_POS,
        ST_ERR,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PS_MUL,
        ST_PS_DONE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    dpc_pkg::dpc_op_t op;

    assign op      = dpc_pkg::dpc_op_t'(s_operation);
    assign s_ready = (state_reg == ST_IDLE);

    // Start items in idle, and the sequence of one tick through the shared datapath.
    always_comb begin
        state_next = state_reg;
        cmd        = dpc_pkg::CMD_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (op == dpc_pkg::OP_START_STRAIGHT || op == dpc_pkg::OP_START_TURN) begin
                        cmd = dpc_pkg::CMD_LOAD_START;
                    end else if (op == dpc_pkg::OP_TICK && status.active) begin
                        cmd        = dpc_pkg::CMD_LATCH;
                        state_next = ST_STEP_MUL;
                    end
                end
            end
            ST_STEP_MUL: begin
                cmd        = dpc_pkg::CMD_STEP_MUL;
                state_next = ST_POS;
            end
            ST_POS: begin
                cmd        = dpc_pkg::CMD_POS;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                cmd        = dpc_pkg::CMD_ERR;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd        = dpc_pkg::CMD_DIV_START;
                state_next = status.sp_zero ? ST_PS_DONE : ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd        = dpc_pkg::CMD_DIV_LOAD;
                    state_next = ST_PS_MUL;
                end
            end
            ST_PS_MUL: begin
                cmd        = dpc_pkg::CMD_PS_MUL;
                state_next = ST_PS_DONE;
            end
            ST_PS_DONE: begin
                cmd        = dpc_pkg::CMD_PS_DONE;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd        = dpc_pkg::CMD_MUL_P;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                cmd        = dpc_pkg::CMD_MUL_I;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd        = dpc_pkg::CMD_MUL_D;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd        = dpc_pkg::CMD_ACC;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd        = dpc_pkg::CMD_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The divider only reports while the sequencer waits for it.
    `DPC_ASSERT_NOW(a_div_done_waited, status.div_done, state_reg == ST_DIV_WAIT, "divider result arrived unexpectedly")

endmodule

>>> sv/drive_pid_position_controller_top.sv
// Channel  | Direction | Handshake         | Payload
// input    | in        | s_valid / s_ready | s_operation, s_target, s_left_count, s_right_count
// result   | out       | m_valid / m_ready | m_motor_power, m_position_error, m_finished
// config   | in        | cfg_write_en      | cfg_index, cfg_data
//
// A tick item passes the sequencer states from accept to result; most of its time goes to
// the 48-step restoring divider that normalizes the error by the setpoint, which is skipped
// with a zero setpoint. Start items and ignored items are handled in the idle state.
// The next item is accepted once the current tick has written its result, even
// while that result still waits in the output register.
// Reset is synchronous and active low; it loads the register defaults and disarms.
module drive_pid_position_controller_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic signed [31:0]                  s_target,
    input  logic signed [23:0]                  s_left_count,
    input  logic signed [23:0]                  s_right_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_motor_power,
    output logic signed [31:0]                  m_position_error,
    output logic                                m_finished,
    input  logic                                cfg_write_en,
    input  logic [dpc_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [dpc_pkg::CfgDataWidth-1:0]    cfg_data
);

    dpc_pkg::dpc_cmd_t    cmd;
    dpc_pkg::dpc_status_t status;

    dpc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .status      (status),
        .cmd         (cmd)
    );

    dpc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_operation      (s_operation),
        .s_target         (s_target),
        .s_left_count     (s_left_count),
        .s_right_count    (s_right_count),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_motor_power    (m_motor_power),
        .m_position_error (m_position_error),
        .m_finished       (m_finished)
    );

endmodule
